// File: sv/assert_macros.svh
// Assertion macros used by the checker file of the resampler.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("resampler assertion failed");

// Clocked assertion that is checked during reset as well.
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("resampler assertion failed");

`endif

// File: sv/lir_pkg.sv
// Package with the widths, types and constants of the linear interpolation resampler.
`timescale 1ns / 1ps

package lir_pkg;

    localparam int TIME_BITS     = 40;
    localparam int VALUE_BITS    = 24;
    localparam int SPACING_BITS  = 32;
    localparam logic [SPACING_BITS-1:0] SPACING_RESET = SPACING_BITS'(1000);

    localparam int SUM_BITS      = (TIME_BITS > SPACING_BITS) ? TIME_BITS : SPACING_BITS;
    localparam int MUL_LO_BITS   = TIME_BITS / 2;
    localparam int MUL_HI_BITS   = TIME_BITS - MUL_LO_BITS;
    localparam int MUL_A_BITS    = MUL_HI_BITS;
    localparam int MUL_P_BITS    = MUL_A_BITS + VALUE_BITS;
    localparam int PROD_BITS     = TIME_BITS + VALUE_BITS;
    localparam int QUO_BITS      = VALUE_BITS + 1;
    localparam int UPPER_BITS    = PROD_BITS - QUO_BITS;
    localparam int PART_BITS     = TIME_BITS + 1;
    localparam int CNT_BITS      = $clog2(QUO_BITS + 1);
    localparam int ACC_BITS      = VALUE_BITS + 3;

    localparam int IN_DATA_BITS  = ((TIME_BITS + VALUE_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_BITS = ((TIME_BITS + VALUE_BITS + 7) / 8) * 8;

    localparam int APB_ADDR_BITS  = 3;
    localparam int APB_DATA_BITS  = 32;
    localparam int REG_INDEX_BITS = APB_ADDR_BITS - 2;
    localparam logic [REG_INDEX_BITS-1:0] REG_SAMPLE_SPACING = REG_INDEX_BITS'(0);

    localparam logic signed [VALUE_BITS-1:0] VALUE_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
    localparam logic signed [VALUE_BITS-1:0] VALUE_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SETUP,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_ACC,
        ST_CHECK,
        ST_DIV,
        ST_FINISH,
        ST_EMIT
    } lir_state_t;

    typedef struct packed {
        logic [MUL_A_BITS-1:0] mul_a;
        logic [VALUE_BITS-1:0] mul_b;
        logic [PART_BITS-1:0]  part;
        logic [TIME_BITS-1:0]  divisor;
    } lir_arith_req_t;

    typedef struct packed {
        logic [MUL_P_BITS-1:0] product;
        logic                  ge;
        logic [PART_BITS-1:0]  diff;
    } lir_arith_rsp_t;

    typedef struct packed {
        logic [VALUE_BITS-1:0] sample_value;
        logic [TIME_BITS-1:0]  sample_time;
    } lir_sample_t;

endpackage

// File: sv/lir_arith.sv
// Shared arithmetic unit: one partial-product multiplier and one compare-and-subtract step.
`timescale 1ns / 1ps

module lir_arith (
    input  lir_pkg::lir_arith_req_t req,
    output lir_pkg::lir_arith_rsp_t rsp
);
    import lir_pkg::*;

    logic [PART_BITS-1:0] divisor_ext;

    always_comb
    begin
        divisor_ext = {1'b0, req.divisor};
        rsp.product = MUL_P_BITS'(req.mul_a) * MUL_P_BITS'(req.mul_b);
        rsp.ge      = (req.part >= divisor_ext);
        rsp.diff    = req.part - divisor_ext;
    end

endmodule

// File: sv/lir_core.sv
// Sequencer and datapath registers of the resampler, driving the shared arithmetic unit.
`timescale 1ns / 1ps

module lir_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [lir_pkg::SPACING_BITS-1:0]    spacing,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [lir_pkg::TIME_BITS-1:0]       in_time,
    input  logic [lir_pkg::VALUE_BITS-1:0]      in_value,
    input  logic                                in_first,
    input  logic                                out_free,
    output logic                                out_load,
    output lir_pkg::lir_sample_t                out_sample
);
    import lir_pkg::*;

    lir_state_t state_reg, state_next;
    logic started_reg, started_next;
    logic [TIME_BITS-1:0]  prev_time_reg, prev_time_next;
    logic [VALUE_BITS-1:0] prev_value_reg, prev_value_next;
    logic [TIME_BITS-1:0]  grid_reg, grid_next;

    logic [TIME_BITS-1:0]  t_reg, t_next;
    logic [VALUE_BITS-1:0] v_reg, v_next;
    logic                  first_reg, first_next;
    logic [VALUE_BITS-1:0] base_reg, base_next;
    logic [TIME_BITS-1:0]  d1_reg, d1_next;
    logic [TIME_BITS-1:0]  dt_reg, dt_next;
    logic [VALUE_BITS-1:0] mv_reg, mv_next;
    logic                  neg_reg, neg_next;
    logic [MUL_P_BITS-1:0] plo_reg, plo_next;
    logic [MUL_P_BITS-1:0] phi_reg, phi_next;
    logic [PROD_BITS-1:0]  prod_reg, prod_next;
    logic [TIME_BITS-1:0]  rem_reg, rem_next;
    logic [QUO_BITS-1:0]   low_reg, low_next;
    logic [QUO_BITS-1:0]   quo_reg, quo_next;
    logic [CNT_BITS-1:0]   cnt_reg, cnt_next;
    logic                  sat_reg, sat_next;
    logic [TIME_BITS-1:0]  res_time_reg, res_time_next;
    logic [VALUE_BITS-1:0] res_value_reg, res_value_next;

    lir_arith_req_t arith_req;
    lir_arith_rsp_t arith_rsp;

    logic                  n1, n2, n3;
    logic [TIME_BITS-1:0]  d1_calc, dt_calc;
    logic [VALUE_BITS:0]   dv, dv_mag;
    logic [TIME_BITS-1:0]  grid_step, start_step;
    logic signed [ACC_BITS-1:0] base_ext, quo_ext, acc;

    lir_arith u_arith (
        .req (arith_req),
        .rsp (arith_rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            started_reg    <= 1'b0;
            prev_time_reg  <= '0;
            prev_value_reg <= '0;
            grid_reg       <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            started_reg    <= started_next;
            prev_time_reg  <= prev_time_next;
            prev_value_reg <= prev_value_next;
            grid_reg       <= grid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg         <= t_next;
        v_reg         <= v_next;
        first_reg     <= first_next;
        base_reg      <= base_next;
        d1_reg        <= d1_next;
        dt_reg        <= dt_next;
        mv_reg        <= mv_next;
        neg_reg       <= neg_next;
        plo_reg       <= plo_next;
        phi_reg       <= phi_next;
        prod_reg      <= prod_next;
        rem_reg       <= rem_next;
        low_reg       <= low_next;
        quo_reg       <= quo_next;
        cnt_reg       <= cnt_next;
        sat_reg       <= sat_next;
        res_time_reg  <= res_time_next;
        res_value_reg <= res_value_next;
    end

    // Differences between the stored point, the grid time and the new point, the next grid times and the signed sum.
    always_comb
    begin
        n1         = (grid_reg < prev_time_reg);
        d1_calc    = n1 ? (prev_time_reg - grid_reg) : (grid_reg - prev_time_reg);
        n2         = (t_reg < prev_time_reg);
        dt_calc    = n2 ? (prev_time_reg - t_reg) : (t_reg - prev_time_reg);
        dv         = {v_reg[VALUE_BITS-1], v_reg} - {prev_value_reg[VALUE_BITS-1], prev_value_reg};
        n3         = dv[VALUE_BITS];
        dv_mag     = n3 ? (~dv + 1'b1) : dv;
        grid_step  = TIME_BITS'(SUM_BITS'(grid_reg) + SUM_BITS'(spacing));
        start_step = TIME_BITS'(SUM_BITS'(t_reg) + SUM_BITS'(spacing));
        base_ext   = ACC_BITS'(signed'(base_reg));
        quo_ext    = signed'(ACC_BITS'(quo_reg));
        acc        = neg_reg ? (base_ext - quo_ext) : (base_ext + quo_ext);
    end

    always_comb
    begin
        state_next      = state_reg;
        started_next    = started_reg;
        prev_time_next  = prev_time_reg;
        prev_value_next = prev_value_reg;
        grid_next       = grid_reg;
        t_next          = t_reg;
        v_next          = v_reg;
        first_next      = first_reg;
        base_next       = base_reg;
        d1_next         = d1_reg;
        dt_next         = dt_reg;
        mv_next         = mv_reg;
        neg_next        = neg_reg;
        plo_next        = plo_reg;
        phi_next        = phi_reg;
        prod_next       = prod_reg;
        rem_next        = rem_reg;
        low_next        = low_reg;
        quo_next        = quo_reg;
        cnt_next        = cnt_reg;
        sat_next        = sat_reg;
        res_time_next   = res_time_reg;
        res_value_next  = res_value_reg;
        in_ready        = 1'b0;
        out_load        = 1'b0;

        arith_req.mul_a   = '0;
        arith_req.mul_b   = mv_reg;
        arith_req.part    = '0;
        arith_req.divisor = dt_reg;

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    t_next     = in_time;
                    v_next     = in_value;
                    first_next = in_first;
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                prev_time_next  = t_reg;
                prev_value_next = v_reg;
                if (first_reg || !started_reg)
                begin
                    res_time_next  = t_reg;
                    res_value_next = v_reg;
                    grid_next      = start_step;
                    started_next   = 1'b1;
                    state_next     = ST_EMIT;
                end
                else if (t_reg >= grid_reg)
                begin
                    res_time_next = grid_reg;
                    grid_next     = grid_step;
                    if (t_reg == prev_time_reg)
                    begin
                        res_value_next = v_reg;
                        state_next     = ST_EMIT;
                    end
                    else
                    begin
                        d1_next    = d1_calc;
                        dt_next    = dt_calc;
                        mv_next    = dv_mag[VALUE_BITS-1:0];
                        neg_next   = n1 ^ n2 ^ n3;
                        base_next  = prev_value_reg;
                        state_next = ST_MUL_LO;
                    end
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_MUL_LO:
            begin
                arith_req.mul_a = MUL_A_BITS'(d1_reg[MUL_LO_BITS-1:0]);
                plo_next        = arith_rsp.product;
                state_next      = ST_MUL_HI;
            end
            ST_MUL_HI:
            begin
                arith_req.mul_a = d1_reg[TIME_BITS-1:MUL_LO_BITS];
                phi_next        = arith_rsp.product;
                state_next      = ST_ACC;
            end
            ST_ACC:
            begin
                prod_next  = PROD_BITS'(plo_reg) + (PROD_BITS'(phi_reg) << MUL_LO_BITS);
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                // A quotient that does not fit in QUO_BITS saturates in any case.
                arith_req.part = PART_BITS'(prod_reg[PROD_BITS-1:QUO_BITS]);
                sat_next       = arith_rsp.ge;
                rem_next       = TIME_BITS'(prod_reg[PROD_BITS-1:QUO_BITS]);
                low_next       = prod_reg[QUO_BITS-1:0];
                quo_next       = '0;
                cnt_next       = '0;
                state_next     = arith_rsp.ge ? ST_FINISH : ST_DIV;
            end
            ST_DIV:
            begin
                arith_req.part = {rem_reg, low_reg[QUO_BITS-1]};
                rem_next       = arith_rsp.ge ? arith_rsp.diff[TIME_BITS-1:0]
                                              : arith_req.part[TIME_BITS-1:0];
                quo_next       = {quo_reg[QUO_BITS-2:0], arith_rsp.ge};
                low_next       = {low_reg[QUO_BITS-2:0], 1'b0};
                cnt_next       = cnt_reg + 1'b1;
                if (cnt_reg == CNT_BITS'(QUO_BITS - 1))
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (sat_reg)
                begin
                    res_value_next = neg_reg ? VALUE_MIN : VALUE_MAX;
                end
                else if (acc > ACC_BITS'(VALUE_MAX))
                begin
                    res_value_next = VALUE_MAX;
                end
                else if (acc < ACC_BITS'(VALUE_MIN))
                begin
                    res_value_next = VALUE_MIN;
                end
                else
                begin
                    res_value_next = acc[VALUE_BITS-1:0];
                end
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_sample.sample_time  = res_time_reg;
    assign out_sample.sample_value = res_value_reg;

endmodule

// File: sv/linear_interp_resampler.sv
// A first point or a point at an already seen time goes from SETUP to EMIT and gives its word.
// An interpolated point passes MUL_LO, MUL_HI, ACC, CHECK, the 25-step divide loop (skipped on saturation), FINISH.
// A point before the next grid time gives no word, and the sequencer goes from SETUP back to IDLE.
// The input waits while an item is in the sequencer.
// Reset: rst_n clears the grid and the stored point and empties the output register at once;
// spacing is 1000.
`timescale 1ns / 1ps

module linear_interp_resampler (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [lir_pkg::APB_ADDR_BITS-1:0]     paddr,
    input  logic [lir_pkg::APB_DATA_BITS-1:0]     pwdata,
    output logic [lir_pkg::APB_DATA_BITS-1:0]     prdata,
    output logic                                  pready,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [lir_pkg::IN_DATA_BITS-1:0]      s_tdata,  // point_time, point_value
    input  logic [0:0]                            s_tuser,  // first_point
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [lir_pkg::OUT_DATA_BITS-1:0]     m_tdata   // sample_time, sample_value
);
    import lir_pkg::*;

    logic [SPACING_BITS-1:0]   spacing_reg, spacing_next;
    logic                      out_valid_reg, out_valid_next;
    lir_sample_t               out_data_reg, out_data_next;
    logic [REG_INDEX_BITS-1:0] reg_index;
    logic                      out_free;
    logic                      out_load;
    lir_sample_t               core_sample;

    lir_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .spacing    (spacing_reg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_time    (s_tdata[TIME_BITS-1:0]),
        .in_value   (s_tdata[TIME_BITS+VALUE_BITS-1:TIME_BITS]),
        .in_first   (s_tuser[0]),
        .out_free   (out_free),
        .out_load   (out_load),
        .out_sample (core_sample)
    );

    assign reg_index = paddr[APB_ADDR_BITS-1:2];
    assign pready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spacing_reg   <= SPACING_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            spacing_reg   <= spacing_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    always_comb
    begin
        spacing_next = spacing_reg;
        prdata       = '0;
        if (reg_index == REG_SAMPLE_SPACING)
        begin
            prdata = APB_DATA_BITS'(spacing_reg);
            if (psel && penable && pwrite)
            begin
                spacing_next = SPACING_BITS'(pwdata);
            end
        end
    end

    always_comb
    begin
        out_free       = !out_valid_reg || m_tready;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_data_next  = core_sample;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_DATA_BITS'(out_data_reg);

endmodule

// File: sv/lir_checker.sv
// Port checker for the resampler and the bind that attaches it.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lir_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic [lir_pkg::IN_DATA_BITS-1:0]  s_tdata,
    input logic [0:0]                        s_tuser,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [lir_pkg::OUT_DATA_BITS-1:0] m_tdata
);
    import lir_pkg::*;

    logic                 in_accept;
    logic                 first_in;
    logic [TIME_BITS-1:0] s_time;
    logic [TIME_BITS-1:0] m_time;

    assign in_accept = s_tvalid && s_tready;
    assign first_in  = in_accept && s_tuser[0] && !m_tvalid;
    assign s_time    = s_tdata[TIME_BITS-1:0];
    assign m_time    = m_tdata[TIME_BITS-1:0];

    // The output register is empty in the cycle after reset is seen.
    `ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !m_tvalid)

    // A stalled output word keeps its value.
    `ASSERT_CLK(a_out_hold, clk, rst_n, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))

    // The sequencer is busy in the cycle after it takes a word.
    `ASSERT_CLK(a_busy_after_accept, clk, rst_n, in_accept |=> !s_tready)

    // A first point taken while the output register is empty reaches that register with its time unchanged.
    `ASSERT_CLK(a_first_passes, clk, rst_n, first_in |-> ##3 (m_tvalid && m_time == $past(s_time, 3)))

endmodule

bind linear_interp_resampler lir_checker u_lir_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// File: tb/sv/linear_interp_resampler_test.sv
// Self-checking testbench for the linear interpolation resampler with a stream driver and monitor.
`timescale 1ns / 1ps

module linear_interp_resampler_test;

    import lir_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES = 400;
    localparam logic [127:0] QUOTIENT_CAP = 128'(1) << 36;
    localparam logic [TIME_BITS-1:0] TIME_MAX = '1;
    localparam logic [APB_ADDR_BITS-1:0] SPACING_ADDR = {REG_SAMPLE_SPACING, 2'b00};

    typedef struct {
        logic [TIME_BITS-1:0]         point_time;
        logic signed [VALUE_BITS-1:0] point_value;
        logic                         first_point;
    } point_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [APB_ADDR_BITS-1:0] paddr = '0;
    logic [APB_DATA_BITS-1:0] pwdata = '0;
    logic [APB_DATA_BITS-1:0] prdata;
    logic pready;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_DATA_BITS-1:0] s_tdata = '0;     // point_time, point_value
    logic [0:0] s_tuser = '0;                  // first_point
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_DATA_BITS-1:0] m_tdata;         // sample_time, sample_value

    point_t pending_points[$];
    point_t offered_point;
    lir_sample_t expected_samples[$];

    logic [SPACING_BITS-1:0] spacing_reg = SPACING_RESET;
    logic [TIME_BITS-1:0] grid_time = '0;
    logic [TIME_BITS-1:0] last_time = '0;
    logic signed [VALUE_BITS-1:0] last_value = '0;
    bit wave_started = 1'b0;

    bit quiet_phase = 1'b0;
    int error_count = 0;
    int cycle_count = 0;
    int gap_left = 0;
    int stall_left = 0;
    int hold_left = 0;
    int hold_requests = 0;
    int holds_served = 0;

    linear_interp_resampler i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 clk = ~clk;

    function automatic bit resample_point(input point_t pt, output lir_sample_t word);
        logic [TIME_BITS-1:0] d1;
        logic [TIME_BITS-1:0] dt;
        logic signed [VALUE_BITS+1:0] dv;
        logic [VALUE_BITS:0] mv;
        logic [127:0] quo;
        logic signed [63:0] base;
        logic signed [63:0] q64;
        logic signed [63:0] acc;
        bit n1;
        bit n2;
        bit n3;
        bit emit;
        emit = 1'b0;
        word = '0;
        if (pt.first_point || !wave_started) begin
            word.sample_time = pt.point_time;
            word.sample_value = pt.point_value;
            grid_time = pt.point_time + spacing_reg;
            wave_started = 1'b1;
            emit = 1'b1;
        end
        else if (pt.point_time >= grid_time) begin
            if (pt.point_time == last_time) begin
                word.sample_value = pt.point_value;
            end
            else begin
                n1 = grid_time < last_time;
                d1 = n1 ? last_time - grid_time : grid_time - last_time;
                n2 = pt.point_time < last_time;
                dt = n2 ? last_time - pt.point_time : pt.point_time - last_time;
                dv = pt.point_value - last_value;
                n3 = dv < 0;
                mv = (VALUE_BITS+1)'(n3 ? -dv : dv);
                quo = (128'(d1) * 128'(mv)) / 128'(dt);
                if (quo > QUOTIENT_CAP) begin
                    quo = QUOTIENT_CAP;
                end
                base = last_value;
                q64 = quo[63:0];
                acc = ((n1 != n2) != n3) ? base - q64 : base + q64;
                if (acc > VALUE_MAX) begin
                    acc = VALUE_MAX;
                end
                else if (acc < VALUE_MIN) begin
                    acc = VALUE_MIN;
                end
                word.sample_value = acc[VALUE_BITS-1:0];
            end
            word.sample_time = grid_time;
            grid_time = grid_time + spacing_reg;
            emit = 1'b1;
        end
        last_time = pt.point_time;
        last_value = pt.point_value;
        return emit;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 60);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        lir_sample_t word;
        if (!rst_n) begin
            s_tvalid <= 1'b0;
            gap_left <= 0;
        end
        else begin
            if (s_tvalid && s_tready) begin
                if (resample_point(offered_point, word)) begin
                    expected_samples = {expected_samples, word};
                end
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    s_tvalid <= 1'b0;
                end
                else if (pending_points.size() > 0) begin
                    offered_point = pending_points.pop_front();
                    s_tdata <= {offered_point.point_value, offered_point.point_time};
                    s_tuser <= offered_point.first_point;
                    s_tvalid <= 1'b1;
                    gap_left <= quiet_phase ? 0 : pick_gap();
                end
                else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        lir_sample_t got;
        lir_sample_t want;
        if (!rst_n) begin
            m_tready <= 1'b0;
        end
        else begin
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (expected_samples.size() == 0) begin
                    $display("%0t: unexpected word, expected none, actual time %h value %h",
                             $realtime, got.sample_time, got.sample_value);
                    error_count++;
                end
                else begin
                    want = expected_samples.pop_front();
                    if (got.sample_time !== want.sample_time) begin
                        $display("%0t: sample_time mismatch, expected %h actual %h",
                                 $realtime, want.sample_time, got.sample_time);
                        error_count++;
                    end
                    if (got.sample_value !== want.sample_value) begin
                        $display("%0t: sample_value mismatch, expected %h actual %h",
                                 $realtime, want.sample_value, got.sample_value);
                        error_count++;
                    end
                end
            end
            if (holds_served != hold_requests) begin
                holds_served <= holds_served + 1;
                hold_left <= HOLD_CYCLES;
                m_tready <= 1'b0;
            end
            else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_tready <= 1'b0;
            end
            else if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                m_tready <= 1'b0;
            end
            else if (quiet_phase) begin
                m_tready <= 1'b1;
            end
            else begin
                case ($urandom_range(0, 19))
                    0, 1, 2, 3, 4: begin
                        stall_left <= $urandom_range(0, 3);
                        m_tready <= 1'b0;
                    end
                    5: begin
                        stall_left <= $urandom_range(10, 40);
                        m_tready <= 1'b0;
                    end
                    default: m_tready <= 1'b1;
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("linear_interp_resampler test failed");
            $finish;
        end
    end

    task automatic write_spacing(input logic [SPACING_BITS-1:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= SPACING_ADDR;
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        spacing_reg = value;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== value) begin
            $display("%0t: sample_spacing read-back mismatch, expected %h actual %h",
                     $realtime, value, prdata);
            error_count++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic push_point(input logic [TIME_BITS-1:0] t, input logic signed [VALUE_BITS-1:0] v,
                              input logic first);
        point_t pt;
        pt.point_time = t;
        pt.point_value = v;
        pt.first_point = first;
        pending_points = {pending_points, pt};
    endtask

    task automatic wait_drained();
        while (pending_points.size() != 0 || s_tvalid || expected_samples.size() != 0) begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic signed [VALUE_BITS-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return VALUE_MAX;
            1: return VALUE_MIN;
            default: return VALUE_BITS'($urandom);
        endcase
    endfunction

    task automatic queue_waveforms(input int count);
        logic [63:0] span;
        logic [TIME_BITS-1:0] t;
        logic signed [VALUE_BITS-1:0] v;
        int len;
        int k;
        int made;
        made = 0;
        span = 64'(spacing_reg) * 2 + 1;
        while (made < count) begin
            if ($urandom_range(0, 99) < 80) begin
                len = $urandom_range(3, 40);
                t = ($urandom_range(0, 3) == 0) ? TIME_BITS'({$urandom, $urandom})
                                                : TIME_BITS'($urandom_range(0, 5000));
                v = pick_value();
                push_point(t, v, 1'b1);
                made++;
                for (int i = 0; i < len && made < count; i++) begin
                    case ($urandom_range(0, 19))
                        0: t = t;
                        1: t = t - TIME_BITS'({$urandom, $urandom} % span);
                        default: t = t + TIME_BITS'({$urandom, $urandom} % span);
                    endcase
                    k = $urandom_range(0, VALUE_BITS - 1);
                    if ($urandom_range(0, 7) == 0) begin
                        v = pick_value();
                    end
                    else begin
                        v = v + VALUE_BITS'($signed($urandom_range(0, 2 << k)) - (1 << k));
                    end
                    push_point(t, v, 1'b0);
                    made++;
                end
            end
            else begin
                push_point(TIME_BITS'({$urandom, $urandom}), VALUE_BITS'($urandom),
                           $urandom_range(0, 3) == 0);
                made++;
            end
        end
    endtask

    initial
    begin
        logic [SPACING_BITS-1:0] spacings[5];
        spacings[0] = 1;
        spacings[1] = '1;
        spacings[2] = $urandom_range(2, 5000);
        spacings[3] = $urandom;
        spacings[4] = 37;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        write_spacing(SPACING_RESET);
        push_point(500, 100, 1'b0);
        push_point(800, -200, 1'b0);
        push_point(2000, VALUE_MAX, 1'b0);
        push_point(9000, 1, 1'b0);
        push_point(9000, -3, 1'b0);
        push_point(6000, VALUE_MAX, 1'b0);
        push_point(7000, VALUE_MIN, 1'b0);
        push_point(100000, VALUE_MAX, 1'b0);
        push_point(50, -1, 1'b1);
        push_point(1200, VALUE_MIN, 1'b0);
        push_point(TIME_MAX, VALUE_MIN, 1'b1);
        push_point(2000, VALUE_MAX, 1'b0);
        push_point(TIME_MAX, VALUE_MAX, 1'b0);
        push_point(0, 0, 1'b1);
        push_point(1000, VALUE_MAX, 1'b0);
        push_point(2000, VALUE_MIN, 1'b0);
        wait_drained();

        write_spacing('0);
        push_point(100, 10, 1'b1);
        push_point(100, 20, 1'b0);
        push_point(50, 25, 1'b0);
        push_point(200, 30, 1'b0);
        push_point(300, 40, 1'b0);
        wait_drained();

        for (int p = 0; p < 5; p++) begin
            write_spacing(spacings[p]);
            quiet_phase = (p == 4);
            queue_waveforms(345);
            if (p == 2) begin
                while (pending_points.size() > 300) begin
                    @(posedge clk);
                end
                hold_requests <= hold_requests + 1;
            end
            wait_drained();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0) begin
            $display("linear_interp_resampler test passed");
        end
        else begin
            $display("linear_interp_resampler test failed");
        end
        $finish;
    end

endmodule
